[sv/esfc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the EEPROM shadow flush controller.
// No dependencies.
package esfc_pkg;

    localparam int EEPROM_BYTES = 16384;
    localparam int SECTOR_BYTES = 4096;
    localparam int ADDR_W       = $clog2(EEPROM_BYTES);
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int NUM_SECTORS  = 4;

    localparam logic [15:0] QUIET_RESET = 16'd200;
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;

    localparam logic [2:0] ACT_READ      = 3'd0;
    localparam logic [2:0] ACT_WRITE     = 3'd1;
    localparam logic [2:0] ACT_UPDATE    = 3'd2;
    localparam logic [2:0] ACT_LOAD      = 3'd3;
    localparam logic [2:0] ACT_TICK      = 3'd4;
    localparam logic [2:0] ACT_FLUSH_ONE = 3'd5;
    localparam logic [2:0] ACT_FLUSH_ALL = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] byte_address;
        logic [7:0]  write_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        flush_valid;
        logic [4:0]  flush_sector;
        logic [3:0]  dirty_bits;
        logic [31:0] flush_total;
        logic        last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [1:0] lowest_dirty(input logic [3:0] mask);
        logic [1:0] idx;
        idx = 2'd0;
        for (int i = NUM_SECTORS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = 2'(i);
            end
        end
        return idx;
    endfunction

endpackage

[sv/esfc_shadow_ram.sv]
`timescale 1ns / 1ps
// Byte shadow store: one write port, one registered read port.
// Depends on esfc_pkg.
module esfc_shadow_ram (
    input  logic              clk,
    input  esfc_pkg::ram_req_t ram_req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [esfc_pkg::EEPROM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        rdata_reg <= mem[ram_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/esfc_ctrl.sv]
`timescale 1ns / 1ps
// Request sequencer: clearing pass, read-modify-write of the shadow store,
// dirty mask, quiet counter and flush issue. Depends on esfc_pkg.
module esfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  esfc_pkg::req_t     request,
    input  logic [15:0]        quiet_ticks,
    input  logic [7:0]         ram_rdata,
    output esfc_pkg::ram_req_t ram_req,
    output logic               busy,
    output logic               done,
    output esfc_pkg::res_t     result
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                      state_reg, state_next;
    esfc_pkg::req_t              req_reg, req_next;
    esfc_pkg::res_t              res_reg, res_next;
    logic                        done_reg, done_next;
    logic [3:0]                  dirty_reg, dirty_next;
    logic [15:0]                 quiet_reg, quiet_next;
    logic [31:0]                 total_reg, total_next;
    logic [esfc_pkg::ADDR_W-1:0] clr_reg, clr_next;

    logic        in_range;
    logic [15:0] sector;
    logic [3:0]  mark;
    logic [1:0]  low;
    logic [3:0]  cleared;
    logic [15:0] quiet_inc;
    logic        do_store;
    logic        do_flush;
    logic        is_last;
    logic [7:0]  rd;

    assign in_range  = {1'b0, req_reg.byte_address} < 17'(esfc_pkg::EEPROM_BYTES);
    assign sector    = req_reg.byte_address >> esfc_pkg::SECTOR_SHIFT;
    assign mark      = (sector < 16'(esfc_pkg::NUM_SECTORS)) ? (4'b0001 << sector[1:0]) : 4'b0;
    assign low       = esfc_pkg::lowest_dirty(dirty_reg);
    assign cleared   = dirty_reg & ~(4'b0001 << low);
    assign quiet_inc = (quiet_reg == 16'hFFFF) ? quiet_reg : quiet_reg + 16'd1;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        dirty_next = dirty_reg;
        quiet_next = quiet_reg;
        total_next = total_reg;
        clr_next   = clr_reg;
        do_store   = 1'b0;
        do_flush   = 1'b0;
        is_last    = 1'b1;
        rd         = 8'd0;

        ram_req.we    = 1'b0;
        ram_req.waddr = req_reg.byte_address[esfc_pkg::ADDR_W-1:0];
        ram_req.wdata = req_reg.write_byte;
        ram_req.raddr = request.byte_address[esfc_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = esfc_pkg::ERASED_BYTE;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == esfc_pkg::ADDR_W'(esfc_pkg::EEPROM_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (req_reg.action)
                    esfc_pkg::ACT_READ:
                    begin
                        if (in_range)
                        begin
                            rd = ram_rdata;
                        end
                    end
                    esfc_pkg::ACT_WRITE:
                    begin
                        do_store = in_range;
                    end
                    esfc_pkg::ACT_UPDATE:
                    begin
                        do_store = in_range && (ram_rdata != req_reg.write_byte);
                    end
                    esfc_pkg::ACT_LOAD:
                    begin
                        ram_req.we = in_range;
                    end
                    esfc_pkg::ACT_TICK:
                    begin
                        quiet_next = quiet_inc;
                        do_flush   = (dirty_reg != 4'b0) && (quiet_inc >= quiet_ticks);
                    end
                    esfc_pkg::ACT_FLUSH_ONE:
                    begin
                        do_flush = dirty_reg != 4'b0;
                    end
                    esfc_pkg::ACT_FLUSH_ALL:
                    begin
                        do_flush = dirty_reg != 4'b0;
                        if (do_flush && cleared != 4'b0)
                        begin
                            is_last    = 1'b0;
                            state_next = ST_EXEC;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (do_store)
                begin
                    ram_req.we = 1'b1;
                    dirty_next = dirty_reg | mark;
                    quiet_next = 16'd0;
                end
                if (do_flush)
                begin
                    dirty_next = cleared;
                    total_next = total_reg + 32'd1;
                end

                res_next.read_data    = rd;
                res_next.flush_valid  = do_flush;
                res_next.flush_sector = do_flush ? {3'b0, low} : 5'd0;
                res_next.dirty_bits   = dirty_next;
                res_next.flush_total  = total_next;
                res_next.last         = is_last;
                done_next             = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
            dirty_reg <= 4'b0;
            quiet_reg <= 16'd0;
            total_reg <= 32'd0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            dirty_reg <= dirty_next;
            quiet_reg <= quiet_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

[sv/eeprom_shadow_flush_controller_top.sv]
`timescale 1ns / 1ps
// Top level of the EEPROM shadow flush controller: quiet threshold register,
// sequencer and shadow store. Depends on esfc_pkg, esfc_ctrl, esfc_shadow_ram.
//
// After reset, busy stays high while the shadow store is swept to 0xFF, one
// byte a cycle. A request is taken when start is high and busy is low. The
// shadow store is read at the accepting edge and the request then passes
// through the read-modify-write stage, so its result is shown in the cycle
// right after that, and a new request can be started in the cycle that result
// is shown. Flush-all repeats the read-modify-write stage for each further
// dirty sector, up to four results. Each result is shown for one cycle with
// done high and cannot be held off; last marks the final result of a request.
// quiet_ticks may be written at any time the block is idle.
module eeprom_shadow_flush_controller_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  esfc_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output esfc_pkg::res_t result,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);

    logic [15:0]        quiet_ticks_reg;
    esfc_pkg::ram_req_t ram_req;
    logic [7:0]         ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_ticks_reg <= esfc_pkg::QUIET_RESET;
        end
        else if (cfg_we)
        begin
            quiet_ticks_reg <= cfg_wdata;
        end
    end

    esfc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .quiet_ticks (quiet_ticks_reg),
        .ram_rdata   (ram_rdata),
        .ram_req     (ram_req),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    esfc_shadow_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

endmodule

[sv/esfc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks on the EEPROM shadow flush controller, bound to the top.
// Depends on esfc_pkg.
module esfc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input esfc_pkg::res_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> busy)
        else $error("non-final result while idle");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.flush_valid |-> result.last)
        else $error("status result not final");

    a_flush_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.flush_valid |-> result.read_data == 8'd0)
        else $error("flush result carries read data");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last |=> !done)
        else $error("result directly after final result");

endmodule

bind eeprom_shadow_flush_controller_top esfc_checker u_esfc_checker (.*);

[verif/eeprom_shadow_flush_controller_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for eeprom_shadow_flush_controller_top: directed and random
// requests, checked against an in-bench shadow/dirty/flush predictor. Depends on esfc_pkg.
module eeprom_shadow_flush_controller_top_tb;

    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int         LIMIT_NS   = 2_000_000;

    logic           clk;
    logic           rst_n;
    logic           start;
    esfc_pkg::req_t request;
    logic           busy;
    logic           done;
    esfc_pkg::res_t result;
    logic           cfg_we;
    logic   [15:0]  cfg_wdata;

    eeprom_shadow_flush_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted block state
    logic [7:0]  mirror_bytes [esfc_pkg::EEPROM_BYTES];
    logic [3:0]  mirror_dirty;
    logic [15:0] mirror_quiet;
    logic [31:0] mirror_flushes;
    logic [15:0] mirror_threshold;

    esfc_pkg::req_t req_backlog [$];
    esfc_pkg::res_t due_results [$];

    int   n_queued;
    int   n_accepted;
    int   n_checked;
    int   n_flush_seen;
    int   n_settings;
    int   errors;
    int   gap_left;
    logic no_gaps;
    logic taken;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("[eeprom_shadow_flush_controller_top] ERROR");
        $finish;
    end

    task automatic mark_written(input int addr, input logic [7:0] data);
        int sec;
        mirror_bytes[addr] = data;
        sec = addr / esfc_pkg::SECTOR_BYTES;
        if (sec < esfc_pkg::NUM_SECTORS)
        begin
            mirror_dirty[sec] = 1'b1;
        end
        mirror_quiet = 16'd0;
    endtask

    // clears the lowest dirty sector and fills in a flush request for it
    task automatic take_lowest_sector(output esfc_pkg::res_t flush);
        flush = '0;
        for (int s = 0; s < esfc_pkg::NUM_SECTORS; s++)
        begin
            if (mirror_dirty[s] && !flush.flush_valid)
            begin
                mirror_dirty[s]    = 1'b0;
                mirror_flushes     = mirror_flushes + 32'd1;
                flush.flush_valid  = 1'b1;
                flush.flush_sector = 5'(s);
            end
        end
        flush.dirty_bits  = mirror_dirty;
        flush.flush_total = mirror_flushes;
    endtask

    task automatic apply_request(input esfc_pkg::req_t r);
        esfc_pkg::res_t status;
        esfc_pkg::res_t flush;
        logic in_range;
        int   addr;
        addr     = int'(r.byte_address);
        in_range = addr < esfc_pkg::EEPROM_BYTES;
        status   = '0;
        case (r.action)
            esfc_pkg::ACT_READ:
            begin
                if (in_range)
                begin
                    status.read_data = mirror_bytes[addr];
                end
            end
            esfc_pkg::ACT_WRITE:
            begin
                if (in_range)
                begin
                    mark_written(addr, r.write_byte);
                end
            end
            esfc_pkg::ACT_UPDATE:
            begin
                if (in_range && mirror_bytes[addr] != r.write_byte)
                begin
                    mark_written(addr, r.write_byte);
                end
            end
            esfc_pkg::ACT_LOAD:
            begin
                if (in_range)
                begin
                    mirror_bytes[addr] = r.write_byte;
                end
            end
            esfc_pkg::ACT_TICK:
            begin
                if (mirror_quiet != 16'hFFFF)
                begin
                    mirror_quiet = mirror_quiet + 16'd1;
                end
                if (mirror_dirty != 4'd0 && mirror_quiet >= mirror_threshold)
                begin
                    take_lowest_sector(flush);
                    flush.last = 1'b1;
                    due_results.push_back(flush);
                    return;
                end
            end
            esfc_pkg::ACT_FLUSH_ONE:
            begin
                if (mirror_dirty != 4'd0)
                begin
                    take_lowest_sector(flush);
                    flush.last = 1'b1;
                    due_results.push_back(flush);
                    return;
                end
            end
            esfc_pkg::ACT_FLUSH_ALL:
            begin
                if (mirror_dirty != 4'd0)
                begin
                    while (mirror_dirty != 4'd0)
                    begin
                        take_lowest_sector(flush);
                        flush.last = (mirror_dirty == 4'd0);
                        due_results.push_back(flush);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        status.dirty_bits  = mirror_dirty;
        status.flush_total = mirror_flushes;
        status.last        = 1'b1;
        due_results.push_back(status);
    endtask

    task automatic check_result(input esfc_pkg::res_t got);
        esfc_pkg::res_t want;
        if (due_results.size() == 0)
        begin
            $error("result with no request outstanding: %h", got);
            errors++;
            return;
        end
        want = due_results.pop_front();
        n_checked++;
        if (got.read_data !== want.read_data)
        begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            errors++;
        end
        if (got.flush_valid !== want.flush_valid)
        begin
            $error("flush_valid: expected %0b, got %0b", want.flush_valid, got.flush_valid);
            errors++;
        end
        if (got.flush_sector !== want.flush_sector)
        begin
            $error("flush_sector: expected %0d, got %0d", want.flush_sector, got.flush_sector);
            errors++;
        end
        if (got.dirty_bits !== want.dirty_bits)
        begin
            $error("dirty_bits: expected %0h, got %0h", want.dirty_bits, got.dirty_bits);
            errors++;
        end
        if (got.flush_total !== want.flush_total)
        begin
            $error("flush_total: expected %0d, got %0d", want.flush_total, got.flush_total);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
        end
    endtask

    // monitor: requests are predicted at acceptance, results checked in order
    always @(posedge clk)
    begin
        taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_request(request);
                n_accepted++;
            end
            if (done)
            begin
                if (result.flush_valid === 1'b1)
                begin
                    n_flush_seen++;
                end
                check_result(result);
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        esfc_pkg::req_t nxt;
        logic go;
        go  = 1'b0;
        nxt = '0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
            end
            else if (req_backlog.size() > 0)
            begin
                nxt = req_backlog.pop_front();
                go  = 1'b1;
                if (!no_gaps && $urandom_range(0, 4) == 0)
                begin
                    gap_left <= $urandom_range(1, 12);
                end
            end
            start <= go;
            if (go)
            begin
                request <= nxt;
            end
        end
    end

    task automatic queue_request(input logic [2:0] act, input logic [15:0] addr,
                                 input logic [7:0] data);
        esfc_pkg::req_t r;
        r.action       = act;
        r.byte_address = addr;
        r.write_byte   = data;
        req_backlog.push_back(r);
        n_queued++;
    endtask

    function automatic esfc_pkg::req_t random_request();
        esfc_pkg::req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            r.action = esfc_pkg::ACT_READ;
        else if (pick < 36)
            r.action = esfc_pkg::ACT_WRITE;
        else if (pick < 50)
            r.action = esfc_pkg::ACT_UPDATE;
        else if (pick < 59)
            r.action = esfc_pkg::ACT_LOAD;
        else if (pick < 82)
            r.action = esfc_pkg::ACT_TICK;
        else if (pick < 90)
            r.action = esfc_pkg::ACT_FLUSH_ONE;
        else if (pick < 97)
            r.action = esfc_pkg::ACT_FLUSH_ALL;
        else
            r.action = ACT_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            r.byte_address = {2'b00, 2'($urandom_range(0, 3)), 9'd0, 3'($urandom_range(0, 7))};
        else if (pick < 85)
            r.byte_address = 16'($urandom_range(0, esfc_pkg::EEPROM_BYTES - 1));
        else
            r.byte_address = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0: r.write_byte = 8'h00;
            1: r.write_byte = 8'hFF;
            2: r.write_byte = 8'h5A;
            3: r.write_byte = 8'hA5;
            default: r.write_byte = 8'($urandom);
        endcase
        return r;
    endfunction

    task automatic queue_random(input int count);
        int pushed;
        int run;
        pushed = 0;
        while (pushed < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                run = $urandom_range(3, 24);
                repeat (run) queue_request(esfc_pkg::ACT_TICK, 16'($urandom), 8'($urandom));
                pushed += run;
            end
            else
            begin
                req_backlog.push_back(random_request());
                n_queued++;
                pushed++;
            end
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || due_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_quiet_ticks(input logic [15:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror_threshold = value;
        n_settings++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        gap_left     = 0;
        no_gaps      = 1'b0;
        taken        = 1'b0;
        n_queued     = 0;
        n_accepted   = 0;
        n_checked    = 0;
        n_flush_seen = 0;
        n_settings   = 1;
        errors       = 0;
        foreach (mirror_bytes[i])
        begin
            mirror_bytes[i] = esfc_pkg::ERASED_BYTE;
        end
        mirror_dirty     = '0;
        mirror_quiet     = '0;
        mirror_flushes   = '0;
        mirror_threshold = esfc_pkg::QUIET_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, at the reset threshold
        queue_request(esfc_pkg::ACT_READ, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_READ, 16'd16383, 8'hFF);
        queue_request(esfc_pkg::ACT_READ, 16'd16384, 8'h00);
        queue_request(esfc_pkg::ACT_READ, 16'hFFFF, 8'hFF);
        queue_request(esfc_pkg::ACT_WRITE, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_WRITE, 16'd16383, 8'hFF);
        queue_request(esfc_pkg::ACT_WRITE, 16'hFFFF, 8'h55);
        queue_request(esfc_pkg::ACT_UPDATE, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_UPDATE, 16'd4096, 8'h12);
        queue_request(esfc_pkg::ACT_UPDATE, 16'd40000, 8'h77);
        queue_request(esfc_pkg::ACT_LOAD, 16'd8192, 8'hAB);
        queue_request(esfc_pkg::ACT_LOAD, 16'hFFFF, 8'hCD);
        queue_request(esfc_pkg::ACT_READ, 16'd8192, 8'h00);
        queue_request(esfc_pkg::ACT_READ, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_TICK, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_FLUSH_ONE, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_FLUSH_ALL, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_FLUSH_ALL, 16'd0, 8'h00);
        queue_request(esfc_pkg::ACT_FLUSH_ONE, 16'd0, 8'h00);
        queue_request(ACT_UNUSED, 16'hFFFF, 8'hFF);
        queue_request(esfc_pkg::ACT_WRITE, 16'd12288, 8'hAA);
        queue_request(esfc_pkg::ACT_WRITE, 16'd8192, 8'h55);
        queue_request(esfc_pkg::ACT_WRITE, 16'd4096, 8'hCC);
        queue_request(esfc_pkg::ACT_WRITE, 16'd0, 8'h33);
        queue_request(esfc_pkg::ACT_FLUSH_ALL, 16'd0, 8'h00);

        set_quiet_ticks(16'd0);
        queue_random(70);
        set_quiet_ticks(16'hFFFF);
        queue_random(70);
        set_quiet_ticks(16'd3);
        queue_random(75);
        set_quiet_ticks(16'd1);
        queue_random(75);
        set_quiet_ticks(16'd20);
        queue_random(75);
        set_quiet_ticks(16'd2);
        no_gaps = 1'b1;
        queue_random(80);

        wait_drained();
        repeat (12) @(negedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", due_results.size());
            errors++;
        end
        $display("Ran %0d requests over %0d quiet_ticks settings; %0d results checked,",
                 n_accepted, n_settings, n_checked);
        $display("including %0d sector flush requests.", n_flush_seen);
        if (errors == 0)
        begin
            $display("[eeprom_shadow_flush_controller_top] OK");
        end
        else
        begin
            $display("[eeprom_shadow_flush_controller_top] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/esfc_pkg.sv
sv/esfc_shadow_ram.sv
sv/esfc_ctrl.sv
sv/eeprom_shadow_flush_controller_top.sv
sv/esfc_checker.sv
verif/eeprom_shadow_flush_controller_top_tb.sv
